// ===== hdl/lab_pkg.sv =====
// Shared types, widths and helpers of the look-at basis pipeline.
// Used by lab_norm and look_at_basis; no dependencies of its own.
package lab_pkg;

  localparam int COMP_W   = 32;                 // component width into a normaliser
  localparam int Q_W      = 16;                 // Q1.14 result width
  localparam int MAG_W    = 15;                 // magnitude after range shift
  localparam int SQ_W     = 2 * MAG_W;          // square of a magnitude
  localparam int LEN_W    = 32;                 // sum of three squares
  localparam int QUO_W    = 29;                 // m^2 * 2^28 / L is at most 2^28
  localparam int ROOT_W   = 15;                 // root is at most 16384
  localparam int SFT_W    = 5;
  localparam int SIDE_W   = 97;                 // forward, right, degenerate
  localparam int NORM_STG = 5 + QUO_W + ROOT_W + 1;

  typedef logic [2:0][COMP_W-1:0] vec_t;
  typedef logic [2:0][Q_W-1:0]    qvec_t;
  typedef logic [SIDE_W-1:0]      side_t;

  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
    side_t      side;
  } ctl_t;

  // Right shift that brings the largest magnitude below 2^15
  function automatic logic [SFT_W-1:0] shift_amt(input logic [COMP_W-1:0] m);
    logic [SFT_W-1:0] s;
    s = '0;
    for (int i = MAG_W; i < COMP_W; i++) begin
      if (m[i]) s = SFT_W'(i - MAG_W + 1);
    end
    return s;
  endfunction

endpackage

// ===== hdl/lab_norm.sv =====
// Pipelined vector normaliser to Q1.14: range shift, squares, restoring
// divide m^2*2^28/L one bit per stage, then integer square root one bit per stage.
// Depends on lab_pkg.
module lab_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ce,
  input  logic           in_valid,
  input  lab_pkg::vec_t  in_vec,
  input  lab_pkg::side_t in_side,
  output logic           out_valid,
  output lab_pkg::qvec_t out_q,
  output logic           out_zero,
  output lab_pkg::side_t out_side
);
  import lab_pkg::*;

  logic               vld_r [NORM_STG];
  ctl_t               ctl_r [NORM_STG];

  logic [COMP_W-1:0]  mag_a_r [3];
  logic [COMP_W-1:0]  mag_b_r [3];
  logic [SFT_W-1:0]   sft_b_r;
  logic [MAG_W-1:0]   m_c_r [3];
  logic [SQ_W-1:0]    sq_d_r [3];
  logic [SQ_W-1:0]    sq_e_r [3];
  logic [LEN_W-1:0]   len_e_r;

  logic [LEN_W-1:0]   rem_r   [QUO_W][3];
  logic [LEN_W-1:0]   rem_nxt [QUO_W][3];
  logic [QUO_W-1:0]   quo_r   [QUO_W][3];
  logic [QUO_W-1:0]   quo_nxt [QUO_W][3];
  logic [LEN_W-1:0]   lenp_r  [QUO_W];
  logic [LEN_W-1:0]   lenp_nxt[QUO_W];

  logic [QUO_W-1:0]   dsq_r    [ROOT_W][3];
  logic [QUO_W-1:0]   dsq_nxt  [ROOT_W][3];
  logic [ROOT_W-1:0]  root_r   [ROOT_W][3];
  logic [ROOT_W-1:0]  root_nxt [ROOT_W][3];

  logic [Q_W-1:0]     q_o_r [3];
  ctl_t               ctl_in;

  always_comb begin
    ctl_in.zero = (in_vec[0] == '0) && (in_vec[1] == '0) && (in_vec[2] == '0);
    for (int i = 0; i < 3; i++) ctl_in.neg[i] = in_vec[i][COMP_W-1];
    ctl_in.side = in_side;
  end

  // restoring divide, quotient bit (QUO_W-1-j) at stage j
  always_comb begin
    logic [LEN_W:0]   cand;
    logic [LEN_W:0]   diff;
    logic [QUO_W-1:0] qprev;
    logic [LEN_W-1:0] lsrc;
    for (int j = 0; j < QUO_W; j++) begin
      lsrc = (j == 0) ? len_e_r : lenp_r[j-1];
      lenp_nxt[j] = lsrc;
      for (int i = 0; i < 3; i++) begin
        if (j == 0) begin
          cand  = (LEN_W+1)'(sq_e_r[i]);
          qprev = '0;
        end else begin
          cand  = {rem_r[j-1][i], 1'b0};
          qprev = quo_r[j-1][i];
        end
        diff = cand - {1'b0, lsrc};
        if (cand >= {1'b0, lsrc}) begin
          rem_nxt[j][i] = diff[LEN_W-1:0];
          quo_nxt[j][i] = {qprev[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[j][i] = cand[LEN_W-1:0];
          quo_nxt[j][i] = {qprev[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  // square root, result bit (ROOT_W-1-k) at stage k
  always_comb begin
    logic [QUO_W-1:0]    dprev;
    logic [ROOT_W-1:0]   rprev;
    logic [ROOT_W-1:0]   t;
    logic [2*ROOT_W-1:0] tt;
    for (int k = 0; k < ROOT_W; k++) begin
      for (int i = 0; i < 3; i++) begin
        dprev = (k == 0) ? quo_r[QUO_W-1][i] : dsq_r[k-1][i];
        rprev = (k == 0) ? '0 : root_r[k-1][i];
        t     = rprev | (ROOT_W'(1) << (ROOT_W - 1 - k));
        tt    = t * t;
        dsq_nxt[k][i]  = dprev;
        root_nxt[k][i] = (tt <= (2*ROOT_W)'(dprev)) ? t : rprev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NORM_STG; k++) vld_r[k] <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < NORM_STG; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [COMP_W-1:0] sh;
    if (ce) begin
      ctl_r[0] <= ctl_in;
      for (int k = 1; k < NORM_STG; k++) ctl_r[k] <= ctl_r[k-1];
      for (int i = 0; i < 3; i++) begin
        mag_a_r[i] <= in_vec[i][COMP_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
        mag_b_r[i] <= mag_a_r[i];
        sh          = mag_b_r[i] >> sft_b_r;
        m_c_r[i]   <= sh[MAG_W-1:0];
        sq_d_r[i]  <= m_c_r[i] * m_c_r[i];
        sq_e_r[i]  <= sq_d_r[i];
      end
      sft_b_r <= shift_amt(mag_a_r[0] | mag_a_r[1] | mag_a_r[2]);
      len_e_r <= LEN_W'(sq_d_r[0]) + LEN_W'(sq_d_r[1]) + LEN_W'(sq_d_r[2]);
      for (int j = 0; j < QUO_W; j++) begin
        lenp_r[j] <= lenp_nxt[j];
        for (int i = 0; i < 3; i++) begin
          rem_r[j][i] <= rem_nxt[j][i];
          quo_r[j][i] <= quo_nxt[j][i];
        end
      end
      for (int k = 0; k < ROOT_W; k++) begin
        for (int i = 0; i < 3; i++) begin
          dsq_r[k][i]  <= dsq_nxt[k][i];
          root_r[k][i] <= root_nxt[k][i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (ctl_r[NORM_STG-2].zero)
          q_o_r[i] <= '0;
        else if (ctl_r[NORM_STG-2].neg[i])
          q_o_r[i] <= -Q_W'(root_r[ROOT_W-1][i]);
        else
          q_o_r[i] <= Q_W'(root_r[ROOT_W-1][i]);
      end
    end
  end

  assign out_valid = vld_r[NORM_STG-1];
  assign out_zero  = ctl_r[NORM_STG-1].zero;
  assign out_side  = ctl_r[NORM_STG-1].side;
  assign out_q     = {q_o_r[2], q_o_r[1], q_o_r[0]};

endmodule

// ===== hdl/look_at_basis.sv =====
// Top level of the look-at basis block: difference, three normalisers and
// the cross product between them. Depends on lab_pkg and lab_norm.

// Takes one transaction per cycle unless held and returns the right, up and
// forward axes in Q1.14 through one difference stage, three 50-stage
// normalisers (29 divide stages and 15 square-root stages each) and one
// cross-product stage. The whole pipeline advances together; it holds
// while a result sits at the output and out_tready is low. A zero forward
// vector, or a target straight above or below, gives a zero right and up
// axis and sets out_tuser.
module look_at_basis (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // self_x, self_y, self_z, target_x, target_y, target_z (32 bits each)
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // right_x/y/z, upward_x/y/z, forward_x/y/z (16 bits each)
  output logic [143:0] out_tdata,
  // degenerate
  output logic [0:0]   out_tuser
);
  import lab_pkg::*;

  logic         ce;
  logic         v0_r;
  vec_t         d_r;
  logic         v1, z1, v2, z2, v3, z3;
  qvec_t        f_q, r_q, u_q;
  vec_t         rc;
  side_t        side2_in, side2, side3;
  logic         vx_r;
  logic [COMP_W-1:0] p_r [6];
  side_t        sx_r;
  vec_t         uc;
  qvec_t        f2, r2;

  assign ce        = out_tready | ~out_tvalid;
  assign in_tready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      vx_r <= 1'b0;
    end else if (ce) begin
      v0_r <= in_tvalid;
      vx_r <= v2;
    end
  end

  // saturating difference target - self
  always_ff @(posedge clk) begin
    logic [COMP_W:0] a;
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        a = {in_tdata[96+32*i+31], in_tdata[96+32*i +: 32]}
          - {in_tdata[32*i+31], in_tdata[32*i +: 32]};
        if (a[COMP_W] != a[COMP_W-1])
          d_r[i] <= a[COMP_W] ? {1'b1, {(COMP_W-1){1'b0}}} : {1'b0, {(COMP_W-1){1'b1}}};
        else
          d_r[i] <= a[COMP_W-1:0];
      end
    end
  end

  lab_norm u_fwd (
    .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(v0_r), .in_vec(d_r),
    .in_side('0), .out_valid(v1), .out_q(f_q), .out_zero(z1), .out_side()
  );

  // up x forward = (fz, 0, -fx)
  always_comb begin
    rc[0] = {{(COMP_W-Q_W){f_q[2][Q_W-1]}}, f_q[2]};
    rc[1] = '0;
    rc[2] = -{{(COMP_W-Q_W){f_q[0][Q_W-1]}}, f_q[0]};
    side2_in = {{(SIDE_W-3*Q_W-1){1'b0}}, z1, f_q};
  end

  lab_norm u_rgt (
    .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(v1), .in_vec(rc),
    .in_side(side2_in), .out_valid(v2), .out_q(r_q), .out_zero(z2), .out_side(side2)
  );

  assign f2 = side2[3*Q_W-1:0];
  assign r2 = r_q;

  always_ff @(posedge clk) begin
    if (ce) begin
      p_r[0] <= $signed(f2[1]) * $signed(r2[2]);
      p_r[1] <= $signed(f2[2]) * $signed(r2[1]);
      p_r[2] <= $signed(f2[2]) * $signed(r2[0]);
      p_r[3] <= $signed(f2[0]) * $signed(r2[2]);
      p_r[4] <= $signed(f2[0]) * $signed(r2[1]);
      p_r[5] <= $signed(f2[1]) * $signed(r2[0]);
      sx_r   <= {side2[3*Q_W] | z2, r2, f2};
    end
  end

  always_comb begin
    uc[0] = p_r[0] - p_r[1];
    uc[1] = p_r[2] - p_r[3];
    uc[2] = p_r[4] - p_r[5];
  end

  lab_norm u_up (
    .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(vx_r), .in_vec(uc),
    .in_side(sx_r), .out_valid(v3), .out_q(u_q), .out_zero(z3), .out_side(side3)
  );

  assign out_tvalid = v3;
  assign out_tdata  = {side3[3*Q_W-1:0], u_q, side3[6*Q_W-1:3*Q_W]};
  assign out_tuser  = side3[6*Q_W] | z3;

endmodule

// ===== bench/tb_look_at_basis.sv =====
// Self-checking testbench for look_at_basis: drives position/target
// transactions with random gaps and stalls and checks each basis against a
// local fixed-point predictor held in a small scoreboard class. Needs only the RTL.
`timescale 1ns / 100ps

class basis_scoreboard;
  typedef struct {
    logic [2:0][15:0] rgt, upw, fwd;
    logic             degen;
  } basis_t;

  basis_t pending_q[$];
  int     errors;

  function new();
    errors = 0;
  endfunction

  // Q1.14 unit vector; ok is 0 for a zero-length input
  function automatic void unit_vec(input longint c[3], output longint o[3], output bit ok);
    longint unsigned mag[3];
    longint unsigned len2, rhs, lo, hi, mid;
    int s;
    bit fits;
    ok = 0;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
      if (mag[i] != 0) ok = 1;
      o[i] = 0;
    end
    if (!ok) return;
    s = 0;
    forever begin
      fits = 1;
      for (int i = 0; i < 3; i++)
        if ((mag[i] >> s) >= 32768) fits = 0;
      if (fits) break;
      s++;
    end
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> s;
      len2 += mag[i] * mag[i];
    end
    for (int i = 0; i < 3; i++) begin
      rhs = (mag[i] * mag[i]) << 28;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (mid * mid * len2 <= rhs) lo = mid;
        else hi = mid - 1;
      end
      o[i] = (c[i] < 0) ? -longint'(lo) : longint'(lo);
    end
  endfunction

  function void note_input(input logic [191:0] d);
    longint diff[3], f[3], rc[3], r[3], uc[3], u[3];
    longint a, b;
    bit ok;
    basis_t e;
    e.degen = 0;
    for (int i = 0; i < 3; i++) begin
      a = longint'($signed(d[32*i +: 32]));
      b = longint'($signed(d[32*(i+3) +: 32]));
      diff[i] = b - a;
      if (diff[i] > 64'sd2147483647) diff[i] = 64'sd2147483647;
      if (diff[i] < -64'sd2147483648) diff[i] = -64'sd2147483648;
    end
    unit_vec(diff, f, ok);
    if (!ok) e.degen = 1;
    rc[0] = f[2];
    rc[1] = 0;
    rc[2] = -f[0];
    unit_vec(rc, r, ok);
    if (!ok) e.degen = 1;
    uc[0] = f[1] * r[2] - f[2] * r[1];
    uc[1] = f[2] * r[0] - f[0] * r[2];
    uc[2] = f[0] * r[1] - f[1] * r[0];
    unit_vec(uc, u, ok);
    if (!ok) e.degen = 1;
    for (int i = 0; i < 3; i++) begin
      e.rgt[i] = r[i][15:0];
      e.upw[i] = u[i][15:0];
      e.fwd[i] = f[i][15:0];
    end
    pending_q.push_back(e);
  endfunction

  function void check_result(input logic [143:0] data, input logic degen);
    basis_t e;
    logic [15:0] want;
    string names[9] = '{"right_x", "right_y", "right_z", "upward_x", "upward_y",
                        "upward_z", "forward_x", "forward_y", "forward_z"};
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result tdata=%h tuser=%b", $time, data, degen);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    for (int i = 0; i < 9; i++) begin
      want = (i < 3) ? e.rgt[i] : (i < 6) ? e.upw[i-3] : e.fwd[i-6];
      if (data[16*i +: 16] !== want) begin
        $display("%0t: %s expected %0d actual %0d", $time, names[i],
                 $signed(want), $signed(data[16*i +: 16]));
        errors++;
      end
    end
    if (degen !== e.degen) begin
      $display("%0t: degenerate expected %b actual %b", $time, e.degen, degen);
      errors++;
    end
  endfunction
endclass

module tb_look_at_basis;
  localparam int  N_RANDOM = 1700;
  localparam int  LATENCY  = 152;
  localparam longint CYCLE_LIMIT = 2_000_000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [143:0] out_tdata;
  logic [0:0]   out_tuser;

  basis_scoreboard basis_sb = new();
  int     n_accepted = 0;
  longint cycles = 0;

  always #5 clk = ~clk;

  look_at_basis DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL look_at_basis");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) basis_sb.check_result(out_tdata, out_tuser[0]);

  // mostly short gaps, some long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_point(input logic [191:0] d, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    basis_sb.note_input(d);
    n_accepted++;
  endtask

  function automatic logic [191:0] pack_pos(input logic [31:0] sx, sy, sz, tx, ty, tz);
    return {tz, ty, tx, sz, sy, sx};
  endfunction

  function automatic logic [31:0] corner_val();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'h1;
      4: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [191:0] random_point();
    logic [31:0] s[3], t[3];
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      s[i] = $urandom;
      t[i] = $urandom;
    end
    case (kind)
      4, 5, 6: begin
        // nearby target: small differences, shifts of zero
        for (int i = 0; i < 3; i++)
          t[i] = s[i] + 32'($signed($urandom_range(0, 8000)) - 4000);
      end
      7: begin
        // straight above or below
        t[0] = s[0];
        t[2] = s[2];
      end
      8: begin
        for (int i = 0; i < 3; i++) t[i] = s[i];
      end
      9: begin
        for (int i = 0; i < 3; i++) begin
          s[i] = corner_val();
          t[i] = corner_val();
        end
      end
      default: ;
    endcase
    return pack_pos(s[0], s[1], s[2], t[0], t[1], t[2]);
  endfunction

  // receiver: random stalls, with one long hold-off to fill the pipeline
  initial begin
    bit held;
    int n;
    held = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && n_accepted >= 300) begin
        out_tready <= 1'b0;
        repeat (500) @(posedge clk);
        held = 1;
      end
      out_tready <= 1'b1;
      n = $urandom_range(1, 30);
      repeat (n) @(posedge clk);
      n = idle_len();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero difference, vertical targets, axes, saturating extremes
    send_point(pack_pos(0, 0, 0, 0, 0, 0), 0);
    send_point(pack_pos(32'h1234, 32'h5678, 32'h9abc, 32'h1234, 32'h5678, 32'h9abc), 1);
    send_point(pack_pos(0, 0, 0, 0, 32'h0001_0000, 0), 1);
    send_point(pack_pos(0, 0, 0, 0, 32'hffff_0000, 0), 0);
    send_point(pack_pos(0, 0, 0, 32'h0001_0000, 0, 0), 1);
    send_point(pack_pos(0, 0, 0, 32'hffff_0000, 0, 0), 1);
    send_point(pack_pos(0, 0, 0, 0, 0, 32'h0001_0000), 0);
    send_point(pack_pos(0, 0, 0, 0, 0, 32'hffff_0000), 1);
    send_point(pack_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1);
    send_point(pack_pos(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0);
    send_point(pack_pos(32'h7fff_ffff, 0, 32'h8000_0000, 32'h8000_0000, 0, 32'h7fff_ffff), 1);
    send_point(pack_pos(0, 0, 0, 1, 1, 1), 1);
    send_point(pack_pos(0, 0, 0, 32'hffff_ffff, 1, 32'hffff_ffff), 0);
    send_point(pack_pos(0, 0, 0, 1, 0, 0), 1);
    send_point(pack_pos(0, 0, 0, 32'h7fff, 32'h7fff, 32'h7fff), 1);
    send_point(pack_pos(0, 0, 0, 32'h8000, 32'h8000, 32'h8000), 1);
    send_point(pack_pos(0, 32'h7fff_ffff, 0, 1, 32'h8000_0000, 0), 0);
    send_point(pack_pos(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff), 1);

    for (int k = 0; k < N_RANDOM; k++)
      send_point(random_point(), ((k / 200) % 3) == 1);
    in_tvalid <= 1'b0;

    while (basis_sb.pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 50) @(posedge clk);
    if (basis_sb.errors == 0 && basis_sb.pending_q.size() == 0)
      $display("PASS look_at_basis");
    else
      $display("FAIL look_at_basis");
    $finish;
  end
endmodule
